FILE: rtl/egl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egl_pkg
// Shared types and constants for the gcd/lcm unit.
// ----------------------------------------------------------------------------
package egl_pkg;

  localparam int unsigned DEF_OPERAND_BITS = 31;
  localparam int unsigned GCD_W            = 31;
  localparam int unsigned LCM_W            = 62;
  localparam int unsigned OUT_TDATA_W      = ((GCD_W + LCM_W + 1 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_MOD,
    S_LCM,
    S_MUL
  } egl_state_e;

endpackage

FILE: rtl/euclid_gcd_lcm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclid_gcd_lcm_unit
// Euclid gcd by repeated remainder on one shared restoring divider, then
// lcm = (a / gcd) * b through a single multiplier, with a too-wide flag.
// ----------------------------------------------------------------------------
// One transaction at a time. The number of remainder steps is 0 to about 45
//   at 31 bits; the divider yields one bit per cycle of each remainder or
//   quotient.
// The next operand pair is taken while a finished result waits downstream.
// Reset: rst_ni asynchronous, active low; clears sequencer and output valid.
module euclid_gcd_lcm_unit
  import egl_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = DEF_OPERAND_BITS,
  parameter int unsigned IN_TDATA_W   = ((2 * OPERAND_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // operand_a, operand_b
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // gcd_value, lcm_value, lcm_too_wide
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned W     = OPERAND_BITS;
  localparam int unsigned CNT_W = $clog2(W);

  egl_state_e          state_q, state_d;
  logic [W-1:0]        a_q, a_d;
  logic [W-1:0]        b_q, b_d;
  logic [W-1:0]        x_q, x_d;
  logic [W-1:0]        y_q, y_d;
  logic [W-1:0]        dvs_q, dvs_d;
  logic [W-1:0]        rem_q, rem_d;
  logic [W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // divider step
  logic [W:0]          trial;
  logic [W:0]          diff;
  logic                ge;
  logic [W-1:0]        rem_nx;
  logic [W-1:0]        quo_nx;
  logic                last_bit;

  // multiplier
  logic [2*W-1:0]      prod;
  logic                too_wide;
  logic                out_free;
  logic                in_fire;

  assign trial    = {rem_q, quo_q[W-1]};
  assign diff     = trial - {1'b0, dvs_q};
  assign ge       = (trial >= {1'b0, dvs_q});
  assign rem_nx   = ge ? diff[W-1:0] : trial[W-1:0];
  assign quo_nx   = {quo_q[W-2:0], ge};
  assign last_bit = (cnt_q == CNT_W'(W - 1));

  assign prod     = (2*W)'(quo_q) * (2*W)'(b_q);
  assign too_wide = |prod[2*W-1:W];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    y_d         = y_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          a_d     = s_axis_tdata[W-1:0];
          b_d     = s_axis_tdata[2*W-1:W];
          x_d     = s_axis_tdata[W-1:0];
          y_d     = s_axis_tdata[2*W-1:W];
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        rem_d = '0;
        cnt_d = '0;
        if (y_q != '0) begin
          quo_d   = x_q;
          dvs_d   = y_q;
          state_d = S_MOD;
        end else if (a_q != '0 && b_q != '0) begin
          quo_d   = a_q;
          dvs_d   = x_q;
          state_d = S_LCM;
        end else begin
          quo_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MOD: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 1'b1;
        if (last_bit) begin
          x_d     = y_q;
          y_d     = rem_nx;
          state_d = S_CHK;
        end
      end
      S_LCM: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 1'b1;
        if (last_bit) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (out_free) begin
          out_data_d  = {(OUT_TDATA_W - GCD_W - LCM_W - 1)'(0), too_wide,
                         LCM_W'(prod), GCD_W'(x_q)};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    x_q        <= x_d;
    y_q        <= y_d;
    dvs_q      <= dvs_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD || state_q == S_LCM) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && $past(state_q) == S_MOD) |-> (y_q < $past(dvs_q)))
    else $error("remainder not below divisor");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && !out_free) |=> (state_q == S_MUL && $stable(x_q)))
    else $error("result lost while output register full");
`endif

endmodule
